// ===== hdl/lkvc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lkvc_pkg;

    // Request kinds carried in s_axis_tuser
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_FIND   = 1'b1;

    // Fixed widths of the stream payloads
    localparam int KEY_PORT_W   = 32;
    localparam int VALUE_PORT_W = 32;
    localparam int S_TDATA_W    = KEY_PORT_W + VALUE_PORT_W;
    localparam int M_TDATA_W    = VALUE_PORT_W;

    // Status of one request handed from the tag array to the datapath
    typedef struct packed {
        logic hit;      // key found among the valid entries
        logic val_wr;   // write the value store at the chosen slot
        logic val_rd;   // read the value store at the chosen slot
    } t_tag_status;

endpackage

`default_nettype wire

// ===== hdl/lkvc_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lkvc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        // hold the last read word until the next read
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== hdl/lkvc_tag_array.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lkvc_tag_array #(
    parameter int CAPACITY = 16,
    parameter int KEY_BITS = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic                        i_req_type,
    input  wire logic [KEY_BITS-1:0]         i_key,
    output lkvc_pkg::t_tag_status            o_status,
    output logic      [$clog2(CAPACITY)-1:0] o_slot
);

    import lkvc_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int FW = $clog2(CAPACITY + 1);

    logic [KEY_BITS-1:0] r_key   [CAPACITY];
    logic                r_valid [CAPACITY];
    logic [IW-1:0]       r_rank  [CAPACITY];
    logic [FW-1:0]       r_fill;

    logic                n_valid [CAPACITY];
    logic [IW-1:0]       n_rank  [CAPACITY];
    logic [FW-1:0]       n_fill;
    logic                key_wr;

    logic [CAPACITY-1:0] match;
    logic                hit;
    logic [IW-1:0]       hit_idx;
    logic [IW-1:0]       victim_idx;
    logic                full;
    logic                is_find;
    logic                touch_en;
    logic                alloc_en;
    logic [IW-1:0]       slot;
    logic [IW-1:0]       touch_rank;
    logic [IW-1:0]       newest_rank;

    // Parallel compare and priority pick: lowest index wins
    always_comb begin
        hit_idx    = '0;
        victim_idx = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            match[i] = r_valid[i] && (r_key[i] == i_key);
        end
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit_idx = IW'(i);
            end
            if (r_valid[i] && (r_rank[i] == '0)) begin
                victim_idx = IW'(i);
            end
        end
    end

    assign hit         = |match;
    assign full        = (r_fill == FW'(CAPACITY));
    assign is_find     = (i_req_type == REQ_FIND);
    assign touch_en    = hit || (!is_find && full);
    assign alloc_en    = !hit && !is_find && !full;
    assign slot        = hit ? hit_idx : (full ? victim_idx : r_fill[IW-1:0]);
    assign touch_rank  = r_rank[slot];
    assign newest_rank = IW'(r_fill - FW'(1));
    assign key_wr      = !hit && !is_find;

    always_comb begin
        n_fill = r_fill;
        for (int i = 0; i < CAPACITY; i++) begin
            n_valid[i] = r_valid[i];
            n_rank[i]  = r_rank[i];
        end
        if (touch_en) begin
            // age everything younger than the touched entry by one place
            for (int i = 0; i < CAPACITY; i++) begin
                if (r_valid[i] && (r_rank[i] > touch_rank)) begin
                    n_rank[i] = r_rank[i] - IW'(1);
                end
            end
            n_rank[slot] = newest_rank;
        end else if (alloc_en) begin
            n_valid[slot] = 1'b1;
            n_rank[slot]  = r_fill[IW-1:0];
            n_fill        = r_fill + FW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            for (int i = 0; i < CAPACITY; i++) begin
                r_valid[i] <= 1'b0;
                r_rank[i]  <= '0;
            end
        end else if (i_en) begin
            r_fill <= n_fill;
            for (int i = 0; i < CAPACITY; i++) begin
                r_valid[i] <= n_valid[i];
                r_rank[i]  <= n_rank[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && key_wr) begin
            r_key[slot] <= i_key;
        end
    end

    assign o_status.hit    = hit;
    assign o_status.val_wr = !is_find;
    assign o_status.val_rd = is_find && hit;
    assign o_slot          = slot;

endmodule

`default_nettype wire

// ===== hdl/lru_key_value_cache_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Fully associative key-value cache with least-recently-used replacement.
// Each request beat on s_axis is an insert (tuser 0) or a find (tuser 1) and
// gives exactly one result beat on m_axis: tuser carries hit, tdata the stored
// value on a find hit and zero otherwise. An insert of a present key updates
// its value; a new key fills the next free entry or evicts the least recent
// one when all CAPACITY entries are in use. Keys are compared in parallel and
// all recency ranks are updated in the same cycle, so one request is taken
// every clock while results are being taken. A request beat is held in the
// input register, then its result goes to the result register and the
// registered value store read; a stalled result holds the request behind it.
// Keys beyond KEY_WIDTH and values beyond VALUE_WIDTH bits (at most 32) are
// dropped.
module lru_key_value_cache_top #(
    parameter int CAPACITY    = 16,
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [lkvc_pkg::S_TDATA_W-1:0] s_axis_tdata,  // key, value
    input  wire logic                           s_axis_tuser,  // req_type
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic      [lkvc_pkg::M_TDATA_W-1:0] m_axis_tdata,  // read_value
    output logic                                m_axis_tuser   // hit
);

    import lkvc_pkg::*;

    localparam int KEY_BITS   = (KEY_WIDTH < KEY_PORT_W) ? KEY_WIDTH : KEY_PORT_W;
    localparam int VALUE_BITS = (VALUE_WIDTH < VALUE_PORT_W) ? VALUE_WIDTH : VALUE_PORT_W;
    localparam int IW         = $clog2(CAPACITY);

    logic                  r_in_valid;
    logic                  r_in_type;
    logic [KEY_BITS-1:0]   r_in_key;
    logic [VALUE_BITS-1:0] r_in_value;

    logic                  r_out_valid;
    logic                  r_out_hit;
    logic                  r_out_rdsel;

    logic                  n_in_valid;
    logic                  n_out_valid;

    logic                  advance;
    logic                  in_beat;
    t_tag_status           status;
    logic [IW-1:0]         slot;
    logic [VALUE_BITS-1:0] rd_value;

    // advance the held request when the result register is free or draining
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_beat) begin
            n_in_valid = 1'b1;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (advance) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_in_type  <= s_axis_tuser;
            r_in_key   <= s_axis_tdata[KEY_BITS-1:0];
            r_in_value <= s_axis_tdata[KEY_PORT_W +: VALUE_BITS];
        end
        if (advance) begin
            r_out_hit   <= status.hit;
            r_out_rdsel <= status.val_rd;
        end
    end

    lkvc_tag_array #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS)
    ) u_tags (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (advance),
        .i_req_type (r_in_type),
        .i_key      (r_in_key),
        .o_status   (status),
        .o_slot     (slot)
    );

    lkvc_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (CAPACITY)
    ) u_values (
        .i_clk     (i_clk),
        .i_wr_en   (advance && status.val_wr),
        .i_wr_addr (slot),
        .i_wr_data (r_in_value),
        .i_rd_en   (advance && status.val_rd),
        .i_rd_addr (slot),
        .o_rd_data (rd_value)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_hit;
    assign m_axis_tdata  = r_out_rdsel ? M_TDATA_W'(rd_value) : '0;

endmodule

`default_nettype wire

// ===== tb/lru_key_value_cache_top_tb.sv =====
`timescale 1ns / 1ps

module lru_key_value_cache_top_tb;

    import lkvc_pkg::*;

    localparam int SLOTS       = 16;
    localparam int POOL_SIZE   = 24;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic                    hit;
        logic [VALUE_PORT_W-1:0] read_value;
    } t_lookup_result;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    wire                  s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;   // key, value
    logic                 s_axis_tuser  = REQ_INSERT;   // req_type
    wire                  m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    wire  [M_TDATA_W-1:0] m_axis_tdata;             // read_value
    wire                  m_axis_tuser;             // hit

    lru_key_value_cache_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Shadow copy of the cache contents
    logic [KEY_PORT_W-1:0]   shadow_key   [SLOTS];
    logic [VALUE_PORT_W-1:0] shadow_value [SLOTS];
    bit                      shadow_used  [SLOTS];
    int unsigned             shadow_age   [SLOTS];
    int unsigned             shadow_fill;

    t_lookup_result pending_results[$];
    logic [KEY_PORT_W-1:0] hot_keys[POOL_SIZE];

    int unsigned tx_idle_pct = 0;
    int unsigned rx_stall_pct = 0;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned sent_count = 0;
    int unsigned checked_count = 0;
    int unsigned hit_count = 0;
    int unsigned eviction_count = 0;

    // Make slot e the most recent; younger slots move down one rank
    function automatic void promote_slot(input int e);
        int unsigned r;
        r = shadow_age[e];
        for (int i = 0; i < SLOTS; i++) begin
            if (shadow_used[i] && shadow_age[i] > r) shadow_age[i]--;
        end
        shadow_age[e] = (shadow_fill > 0) ? shadow_fill - 1 : 0;
    endfunction

    function automatic t_lookup_result predict_cache_access(input logic req,
            input logic [KEY_PORT_W-1:0] key, input logic [VALUE_PORT_W-1:0] value);
        t_lookup_result res;
        int             found;
        found = -1;
        res   = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (found < 0 && shadow_used[i] && shadow_key[i] == key) found = i;
        end
        if (req == REQ_FIND) begin
            if (found >= 0) begin
                promote_slot(found);
                res.hit        = 1'b1;
                res.read_value = shadow_value[found];
            end
        end else if (found >= 0) begin
            promote_slot(found);
            shadow_value[found] = value;
            res.hit = 1'b1;
        end else begin
            if (shadow_fill < SLOTS) begin
                found = shadow_fill;
                shadow_used[found] = 1'b1;
                shadow_age[found]  = shadow_fill;
                shadow_fill++;
            end else begin
                found = 0;
                for (int i = SLOTS - 1; i >= 0; i--) begin
                    if (shadow_used[i] && shadow_age[i] == 0) found = i;
                end
                promote_slot(found);
                eviction_count++;
            end
            shadow_key[found]   = key;
            shadow_value[found] = value;
        end
        return res;
    endfunction

    // Present one request, hold it until the beat is taken, then predict
    task automatic send_request(input logic req, input logic [KEY_PORT_W-1:0] key,
            input logic [VALUE_PORT_W-1:0] value);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {value, key};
        s_axis_tuser  <= req;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_results.push_back(predict_cache_access(req, key, value));
        sent_count++;
    endtask

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    always @(posedge i_clk) begin
        t_lookup_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            checked_count++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result beat hit %0b value %h",
                         $time, m_axis_tuser, m_axis_tdata);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (want.hit) hit_count++;
                if (m_axis_tuser !== want.hit) begin
                    $display("%0t: hit mismatch expected %0b actual %0b",
                             $time, want.hit, m_axis_tuser);
                    error_count++;
                end
                if (m_axis_tdata !== want.read_value) begin
                    $display("%0t: read_value mismatch expected %h actual %h",
                             $time, want.read_value, m_axis_tdata);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     pending_results.size());
            $display("FAIL");
            $finish;
        end
    end

    task automatic test_directed_cases();
        send_request(REQ_FIND, 32'h1234_5678, 32'hFFFF_FFFF);  // empty store
        send_request(REQ_INSERT, 32'h0000_0000, 32'h0000_0000);
        send_request(REQ_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(REQ_FIND, 32'hFFFF_FFFF, 32'h0000_0000);  // newest, ranks stay
        send_request(REQ_FIND, 32'h0000_0000, 32'hA5A5_A5A5);
        send_request(REQ_INSERT, 32'h0000_0000, 32'h8000_0001); // overwrite newest
        send_request(REQ_FIND, 32'h0000_0000, 32'h0000_0000);
        for (int i = 0; i < SLOTS - 2; i++)
            send_request(REQ_INSERT, 32'h0100_0000 + i, 32'h5A00_0000 | i);
        // store full: the oldest key goes out
        send_request(REQ_INSERT, 32'h8000_0000, 32'h0F0F_0F0F);
        send_request(REQ_FIND, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(REQ_FIND, 32'h0000_0000, 32'h0000_0000);
    endtask

    // Key pool a little larger than the store: hits, refreshes and evictions mix
    task automatic test_hot_key_churn(input int n_items);
        logic [KEY_PORT_W-1:0] key;
        for (int n = 0; n < n_items; n++) begin
            key = hot_keys[$urandom_range(0, POOL_SIZE - 1)];
            if ($urandom_range(0, 9) < 4) send_request(REQ_FIND, key, $urandom);
            else                          send_request(REQ_INSERT, key, $urandom);
        end
    endtask

    // Fresh random keys, each often looked up straight after it went in
    task automatic test_wide_key_sweep(input int n_items);
        logic [KEY_PORT_W-1:0] last_key;
        logic [KEY_PORT_W-1:0] key;
        last_key = $urandom;
        for (int n = 0; n < n_items; n++) begin
            case ($urandom_range(0, 3))
                0: send_request(REQ_FIND, last_key, $urandom);
                1: send_request(REQ_FIND, $urandom, $urandom);
                default: begin
                    key = $urandom;
                    send_request(REQ_INSERT, key, $urandom);
                    last_key = key;
                end
            endcase
        end
    endtask

    initial begin
        hot_keys[0] = 32'h0000_0000;
        hot_keys[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < POOL_SIZE; i++) hot_keys[i] = $urandom;
        for (int i = 0; i < SLOTS; i++) begin
            shadow_used[i] = 1'b0;
            shadow_age[i]  = 0;
        end
        shadow_fill = 0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();

        tx_idle_pct = 0;  rx_stall_pct = 0;
        test_hot_key_churn(330);
        test_wide_key_sweep(25);
        tx_idle_pct = 75; rx_stall_pct = 0;
        test_hot_key_churn(330);
        test_wide_key_sweep(25);
        tx_idle_pct = 0;  rx_stall_pct = 75;
        test_hot_key_churn(330);
        test_wide_key_sweep(25);
        tx_idle_pct = 7;  rx_stall_pct = 7;
        test_hot_key_churn(330);
        test_wide_key_sweep(25);

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Sent %0d requests, checked %0d results: %0d hits, %0d evictions.",
                 sent_count, checked_count, hit_count, eviction_count);
        $display("Traffic ran back to back, with sender gaps, receiver stalls and both.");
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches", error_count);
            $display("FAIL");
        end
        $finish;
    end

endmodule
